### rtl/core/sfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types and constants of the serial frame receiver
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SUM_W    = 16;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_AW   = 2;

  // start marker, two length bytes, two checksum bytes
  localparam logic [SUM_W-1:0] OVERHEAD_BYTES = 16'd7;
  localparam logic [BYTE_W-1:0] START_RESET   = 8'hAA;

  // register indexes of the configuration port
  localparam logic [CFG_AW-1:0] CFG_START_FIRST  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_START_SECOND = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_START_THIRD  = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_CHK_ERR = 2'd2,
    KIND_LEN_ERR = 2'd3
  } item_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] third;
  } start_seq_t;

  // registered received byte handed to the parser
  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] data;
  } rx_word_t;

  typedef struct packed {
    item_kind_t        kind;
    logic [BYTE_W-1:0] payload;
    logic              frame_end;
    logic [SUM_W-1:0]  sum;
  } out_item_t;

endpackage

### rtl/core/sfr_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_in_stage
// input register for received bytes, refilled in the cycle it is drained
// ----------------------------------------------------------------------------
module sfr_in_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sfr_pkg::BYTE_W-1:0]    in_byte,
  input  logic                          drain,
  output sfr_pkg::rx_word_t             rx_word
);

  logic                       vld_r;
  logic [sfr_pkg::BYTE_W-1:0] data_r;

  assign in_tready    = !vld_r || drain;
  assign rx_word.vld  = vld_r;
  assign rx_word.data = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_byte;
    end
  end

endmodule

### rtl/core/sfr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_parser
// frame state machine with payload sum and the result register
// ----------------------------------------------------------------------------
module sfr_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sfr_pkg::rx_word_t     rx_word,
  input  sfr_pkg::start_seq_t   start_seq,
  output logic                  drain,
  output logic                  out_vld,
  input  logic                  out_rdy,
  output sfr_pkg::out_item_t    out_item
);

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_HUNT3   = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_LEN_LO  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHK_HI  = 3'd6,
    PH_CHK_LO  = 3'd7
  } phase_t;

  phase_t                     phase_r, phase_nxt;
  logic [sfr_pkg::BYTE_W-1:0] len_hi_r, len_hi_nxt;
  logic [sfr_pkg::SUM_W-1:0]  left_r, left_nxt;
  logic [sfr_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [sfr_pkg::BYTE_W-1:0] chk_hi_r, chk_hi_nxt;
  logic                       out_vld_r;
  sfr_pkg::out_item_t         item_r, item_nxt;
  logic                       emit;
  logic                       step;
  phase_t                     restart;
  logic [sfr_pkg::BYTE_W-1:0] b;
  logic [sfr_pkg::SUM_W-1:0]  frame_len;
  logic [sfr_pkg::SUM_W-1:0]  left_dec;

  assign drain    = !out_vld_r || out_rdy;
  assign step     = rx_word.vld && drain;
  assign out_vld  = out_vld_r;
  assign out_item = item_r;

  assign b         = rx_word.data;
  assign restart   = (b == start_seq.first) ? PH_HUNT2 : PH_HUNT1;
  assign frame_len = {len_hi_r, b};
  assign left_dec  = left_r - 16'd1;

  always_comb begin
    phase_nxt  = phase_r;
    len_hi_nxt = len_hi_r;
    left_nxt   = left_r;
    sum_nxt    = sum_r;
    chk_hi_nxt = chk_hi_r;
    emit       = 1'b0;
    item_nxt   = '{kind: sfr_pkg::KIND_PAYLOAD, payload: '0, frame_end: 1'b0, sum: '0};
    unique case (phase_r)
      PH_HUNT1: phase_nxt = restart;
      PH_HUNT2: phase_nxt = (b == start_seq.second) ? PH_HUNT3 : restart;
      PH_HUNT3: phase_nxt = (b == start_seq.third) ? PH_LEN_HI : restart;
      PH_LEN_HI: begin
        len_hi_nxt = b;
        phase_nxt  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        sum_nxt = '0;
        if (frame_len < sfr_pkg::OVERHEAD_BYTES) begin
          emit               = 1'b1;
          item_nxt.kind      = sfr_pkg::KIND_LEN_ERR;
          item_nxt.frame_end = 1'b1;
          left_nxt           = '0;
          phase_nxt          = PH_HUNT1;
        end else begin
          left_nxt  = frame_len - sfr_pkg::OVERHEAD_BYTES;
          phase_nxt = (frame_len == sfr_pkg::OVERHEAD_BYTES) ? PH_CHK_HI : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_nxt          = sum_r + {8'd0, b};
        emit             = 1'b1;
        item_nxt.payload = b;
        left_nxt         = left_dec;
        if (left_dec == '0) begin
          phase_nxt = PH_CHK_HI;
        end
      end
      PH_CHK_HI: begin
        chk_hi_nxt = b;
        phase_nxt  = PH_CHK_LO;
      end
      PH_CHK_LO: begin
        emit               = 1'b1;
        item_nxt.kind      = ({chk_hi_r, b} == sum_r) ? sfr_pkg::KIND_GOOD
                                                      : sfr_pkg::KIND_CHK_ERR;
        item_nxt.frame_end = 1'b1;
        item_nxt.sum       = sum_r;
        phase_nxt          = PH_HUNT1;
      end
      default: phase_nxt = PH_HUNT1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT1;
      len_hi_r  <= '0;
      left_r    <= '0;
      sum_r     <= '0;
      chk_hi_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (step) begin
        phase_r  <= phase_nxt;
        len_hi_r <= len_hi_nxt;
        left_r   <= left_nxt;
        sum_r    <= sum_nxt;
        chk_hi_r <= chk_hi_nxt;
      end
      if (drain) begin
        out_vld_r <= step && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      item_r <= item_nxt;
    end
  end

  // a frame close never carries a payload byte
  a_end_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && item_r.frame_end |-> item_r.kind != sfr_pkg::KIND_PAYLOAD
      && item_r.payload == '0)
    else $error("frame_end on a payload word");

  // payload words carry no sum and never close a frame
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && item_r.kind == sfr_pkg::KIND_PAYLOAD |-> !item_r.frame_end
      && item_r.sum == '0)
    else $error("payload word with status fields set");

  // the payload phase always has bytes to come
  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> left_r != '0)
    else $error("payload phase with no bytes left");

  // a status word sends the parser back to hunting
  a_status_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
    step && emit && item_nxt.frame_end |=> phase_r == PH_HUNT1)
    else $error("no return to hunt after status word");

endmodule

### rtl/core/serial_frame_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_top
// byte stream deframer: start sequence, length, payload, checksum
// ----------------------------------------------------------------------------
// Takes one received byte per clock cycle while the output is not stalled
// by out_tready: a byte passes an input register, then one step of the
// frame state machine and sum, then the result register that drives the
// output. in_tready falls only while both registers are full and
// out_tready is low. Payload bytes come out as they arrive with kind 0;
// each frame closes with one status word (good, checksum error or length
// error) flagged by out_tlast. The start sequence bytes are set through
// the cfg port; the user must write them only while the stream is idle,
// as the block does not enforce this. They reset to 0xAA.
module serial_frame_receiver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [7:0] payload_byte, [23:8] computed_sum
  output logic        out_tlast,   // frame_end
  output logic [1:0]  out_tuser,   // [1:0] item_kind
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  sfr_pkg::start_seq_t start_seq_r;
  sfr_pkg::rx_word_t   rx_word;
  sfr_pkg::out_item_t  out_item;
  logic                drain;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_seq_r <= '{first:  sfr_pkg::START_RESET,
                       second: sfr_pkg::START_RESET,
                       third:  sfr_pkg::START_RESET};
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sfr_pkg::CFG_START_FIRST:  start_seq_r.first  <= cfg_wdata;
        sfr_pkg::CFG_START_SECOND: start_seq_r.second <= cfg_wdata;
        sfr_pkg::CFG_START_THIRD:  start_seq_r.third  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sfr_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .drain     (drain),
    .rx_word   (rx_word)
  );

  sfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_word   (rx_word),
    .start_seq (start_seq_r),
    .drain     (drain),
    .out_vld   (out_tvalid),
    .out_rdy   (out_tready),
    .out_item  (out_item)
  );

  assign out_tdata = {out_item.sum, out_item.payload};
  assign out_tlast = out_item.frame_end;
  assign out_tuser = out_item.kind;

endmodule

### tb/sfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_checker
// watches the byte stream, predicts every deframed word and checks it
// ----------------------------------------------------------------------------
// Keeps its own copy of the start sequence registers and of the frame parser
// state, steps it on every accepted input byte and queues the word that byte
// causes. Every accepted output word is compared field by field with the
// oldest queued word. Leftover words are flagged once end_of_test rises.
module sfr_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,   // [7:0] payload_byte, [23:8] computed_sum
  input  logic        out_tlast,   // frame_end
  input  logic [1:0]  out_tuser,   // [1:0] item_kind
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        end_of_test,
  output int unsigned fail_count,
  output int unsigned results_pending
);

  typedef enum logic [2:0] {
    RX_HUNT1, RX_HUNT2, RX_HUNT3, RX_LEN_HI, RX_LEN_LO, RX_PAYLOAD, RX_CHK_HI, RX_CHK_LO
  } rx_phase_t;

  sfr_pkg::start_seq_t        start_seq;
  rx_phase_t                  rx_phase;
  logic [sfr_pkg::SUM_W-1:0]  frame_len;
  logic [sfr_pkg::SUM_W-1:0]  bytes_left;
  logic [sfr_pkg::SUM_W-1:0]  payload_sum;
  logic [sfr_pkg::BYTE_W-1:0] chk_hi;

  sfr_pkg::out_item_t expected_words[$];
  sfr_pkg::out_item_t oldest_word;
  int unsigned        err_total = 0;
  int unsigned        words_waiting = 0;
  bit                 leftover_done = 1'b0;

  assign fail_count      = err_total;
  assign results_pending = words_waiting;

  // a byte that breaks a partial match may itself open a new one
  function automatic rx_phase_t restart_hunt(input logic [sfr_pkg::BYTE_W-1:0] b);
    return (b == start_seq.first) ? RX_HUNT2 : RX_HUNT1;
  endfunction

  task automatic deframe_byte(input logic [sfr_pkg::BYTE_W-1:0] b);
    sfr_pkg::out_item_t        word;
    logic                      has_word;
    logic [sfr_pkg::SUM_W-1:0] rx_sum;
    word     = '0;
    has_word = 1'b0;
    case (rx_phase)
      RX_HUNT1: rx_phase = restart_hunt(b);
      RX_HUNT2: rx_phase = (b == start_seq.second) ? RX_HUNT3 : restart_hunt(b);
      RX_HUNT3: rx_phase = (b == start_seq.third) ? RX_LEN_HI : restart_hunt(b);
      RX_LEN_HI: begin
        frame_len = {b, 8'h00};
        rx_phase  = RX_LEN_LO;
      end
      RX_LEN_LO: begin
        frame_len   = {frame_len[15:8], b};
        payload_sum = '0;
        if (frame_len < sfr_pkg::OVERHEAD_BYTES) begin
          word.kind      = sfr_pkg::KIND_LEN_ERR;
          word.frame_end = 1'b1;
          has_word       = 1'b1;
          bytes_left     = '0;
          rx_phase       = RX_HUNT1;
        end else begin
          bytes_left = frame_len - sfr_pkg::OVERHEAD_BYTES;
          rx_phase   = (bytes_left == '0) ? RX_CHK_HI : RX_PAYLOAD;
        end
      end
      RX_PAYLOAD: begin
        payload_sum  = payload_sum + sfr_pkg::SUM_W'(b);
        word.kind    = sfr_pkg::KIND_PAYLOAD;
        word.payload = b;
        has_word     = 1'b1;
        bytes_left   = bytes_left - 16'd1;
        if (bytes_left == '0) rx_phase = RX_CHK_HI;
      end
      RX_CHK_HI: begin
        chk_hi   = b;
        rx_phase = RX_CHK_LO;
      end
      default: begin
        rx_sum         = {chk_hi, b};
        word.kind      = (rx_sum == payload_sum) ? sfr_pkg::KIND_GOOD
                                                 : sfr_pkg::KIND_CHK_ERR;
        word.frame_end = 1'b1;
        word.sum       = payload_sum;
        has_word       = 1'b1;
        rx_phase       = RX_HUNT1;
      end
    endcase
    if (has_word) expected_words = {expected_words, word};
  endtask

  task automatic check_field(input string field, input logic [15:0] exp_val,
                             input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s expected 0x%0h actual 0x%0h", field, exp_val, act_val);
      err_total++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start_seq   = {sfr_pkg::START_RESET, sfr_pkg::START_RESET, sfr_pkg::START_RESET};
      rx_phase    = RX_HUNT1;
      frame_len   = '0;
      bytes_left  = '0;
      payload_sum = '0;
      chk_hi      = '0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          sfr_pkg::CFG_START_FIRST:  start_seq.first  = cfg_wdata;
          sfr_pkg::CFG_START_SECOND: start_seq.second = cfg_wdata;
          sfr_pkg::CFG_START_THIRD:  start_seq.third  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) deframe_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: kind %0d data 0x%0h last %0d",
                 out_tuser, out_tdata, out_tlast);
          err_total++;
        end else begin
          oldest_word = expected_words.pop_front();
          check_field("item_kind", 16'(oldest_word.kind), 16'(out_tuser));
          check_field("payload_byte", 16'(oldest_word.payload), 16'(out_tdata[7:0]));
          check_field("frame_end", 16'(oldest_word.frame_end), 16'(out_tlast));
          check_field("computed_sum", oldest_word.sum, out_tdata[23:8]);
        end
      end
      if (end_of_test && !leftover_done) begin
        leftover_done = 1'b1;
        if (expected_words.size() != 0) begin
          $error("%0d expected words never arrived", expected_words.size());
          err_total++;
        end
      end
    end
    words_waiting = expected_words.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the serial frame receiver
// ----------------------------------------------------------------------------
// Sends a few hand-made frames with the reset start sequence, then several
// phases of random traffic, each after a fresh start sequence is loaded
// while the block is drained. Traffic is mostly well-formed frames with
// random payload, with short-length frames, bad checksums, broken start
// sequences and stray bytes mixed in. Most phases idle both sides at random.
module tb;

  localparam int unsigned     CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned     DRAIN_TAIL   = 6;
  localparam int unsigned     PHASE_BYTES  = 200;
  localparam int unsigned     NUM_PHASES   = 8;
  localparam logic [sfr_pkg::CFG_AW-1:0] CFG_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = sfr_pkg::CFG_START_FIRST;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        end_of_test = 1'b0;
  int unsigned fail_count;
  int unsigned results_pending;

  bit                  idle_on = 1'b1;
  bit                  stall_on = 1'b1;
  sfr_pkg::start_seq_t start_cfg = {sfr_pkg::START_RESET, sfr_pkg::START_RESET,
                                    sfr_pkg::START_RESET};
  int unsigned         cycle_count = 0;

  serial_frame_receiver_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  sfr_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .end_of_test(end_of_test), .fail_count(fail_count),
    .results_pending(results_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // output side: ready bursts with random stalls in between
  initial begin : out_ready_gen
    int unsigned ready_len;
    int unsigned stall_len;
    int unsigned r;
    @(posedge clk);
    forever begin
      ready_len = $urandom_range(1, 8);
      r = $urandom_range(0, 99);
      if (!stall_on || r < 60) stall_len = 0;
      else if (r < 93) stall_len = $urandom_range(1, 3);
      else stall_len = $urandom_range(10, 40);
      out_tready <= 1'b1;
      repeat (ready_len) @(posedge clk);
      if (stall_len > 0) begin
        out_tready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    int unsigned r;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    r = $urandom_range(0, 99);
    if (!idle_on || r < 70) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom_range(0, 255));
      repeat (gap) @(posedge clk);
    end
  endtask

  // stray byte that cannot match any start byte, so the parser falls back to hunting
  function automatic logic [7:0] stray_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == start_cfg.first || b == start_cfg.second || b == start_cfg.third);
    return b;
  endfunction

  task automatic send_start();
    send_byte(start_cfg.first);
    send_byte(start_cfg.second);
    send_byte(start_cfg.third);
  endtask

  task automatic send_frame(input int unsigned plen, input bit bad_sum);
    logic [15:0] total;
    logic [15:0] sum;
    logic [7:0]  b;
    total = 16'(plen) + sfr_pkg::OVERHEAD_BYTES;
    sum   = '0;
    send_start();
    send_byte(total[15:8]);
    send_byte(total[7:0]);
    repeat (plen) begin
      b = 8'($urandom_range(0, 255));
      sum = sum + 16'(b);
      send_byte(b);
    end
    if (bad_sum) sum = sum ^ 16'($urandom_range(1, 65535));
    send_byte(sum[15:8]);
    send_byte(sum[7:0]);
  endtask

  task automatic send_broken_start();
    logic [7:0] want;
    logic [7:0] x;
    send_byte(start_cfg.first);
    want = start_cfg.second;
    if ($urandom_range(0, 1) && start_cfg.first == start_cfg.second) begin
      send_byte(start_cfg.second);
      want = start_cfg.third;
    end else if ($urandom_range(0, 1)) begin
      send_byte(start_cfg.second);
      want = start_cfg.third;
    end
    // the breaking byte is often the first start byte, which reopens the hunt
    if ($urandom_range(0, 2) == 0 && start_cfg.first != want) x = start_cfg.first;
    else do x = 8'($urandom_range(0, 255)); while (x == want);
    send_byte(x);
    send_byte(stray_byte());
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // called only once the block is drained
  task automatic load_start_seq(input sfr_pkg::start_seq_t seq);
    cfg_we    <= 1'b1;
    cfg_addr  <= sfr_pkg::CFG_START_FIRST;
    cfg_wdata <= seq.first;
    @(posedge clk);
    cfg_addr  <= CFG_UNUSED;
    cfg_wdata <= 8'($urandom_range(0, 255));
    @(posedge clk);
    cfg_addr  <= sfr_pkg::CFG_START_SECOND;
    cfg_wdata <= seq.second;
    @(posedge clk);
    cfg_addr  <= sfr_pkg::CFG_START_THIRD;
    cfg_wdata <= seq.third;
    @(posedge clk);
    cfg_we    <= 1'b0;
    start_cfg = seq;
  endtask

  task automatic random_traffic(input int unsigned budget);
    int unsigned sent_items;
    int unsigned pick;
    int unsigned r;
    int unsigned plen;
    sent_items = 0;
    while (sent_items < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        r = $urandom_range(0, 99);
        if (r < 60) plen = $urandom_range(0, 8);
        else if (r < 95) plen = $urandom_range(9, 40);
        else plen = $urandom_range(100, 300);
        send_frame(plen, $urandom_range(0, 3) == 0);
        sent_items += plen + 7;
      end else if (pick < 85) begin
        send_start();
        send_byte(8'h00);
        send_byte(8'($urandom_range(0, 6)));
        sent_items += 5;
      end else if (pick < 94) begin
        send_broken_start();
        sent_items += 3;
      end else if (pick < 99) begin
        repeat ($urandom_range(1, 6)) send_byte(stray_byte());
      end else begin
        wait_drained();
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0]          directed_bytes [0:22];
    sfr_pkg::start_seq_t seq;
    directed_bytes = '{
      // one-byte payload of all ones, good checksum
      8'hAA, 8'hAA, 8'hAA, 8'h00, 8'h08, 8'hFF, 8'h00, 8'hFF,
      // empty payload, checksum off by one
      8'hAA, 8'hAA, 8'hAA, 8'h00, 8'h07, 8'h00, 8'h01,
      // start broken at the third byte, then a length just below the minimum
      8'hAA, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'hAA, 8'h00, 8'h06
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: seq = {8'h00, 8'h00, 8'h00};
        1: seq = {8'hFF, 8'hFF, 8'hFF};
        2: seq = {8'h5A, 8'h5A, 8'hC3};
        3: seq = {8'h12, 8'h34, 8'h12};
        NUM_PHASES - 1: seq = {sfr_pkg::START_RESET, sfr_pkg::START_RESET,
                               sfr_pkg::START_RESET};
        default: seq = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255))};
      endcase
      idle_on  = (ph != 3);
      stall_on = (ph != 3) && (ph != 5);
      load_start_seq(seq);
      random_traffic(PHASE_BYTES);
      wait_drained();
    end

    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/sfr_pkg.sv
rtl/core/sfr_in_stage.sv
rtl/core/sfr_parser.sv
rtl/core/serial_frame_receiver_top.sv
tb/sfr_checker.sv
tb/tb.sv
